// ----- rtl/core/etrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package etrm_pkg;

  localparam int SineTableBitsDef = 12;
  localparam int AngleW = 16;
  localparam int TransW = 32;
  localparam int QFrac = 14;
  localparam logic [63:0] HalfPiQ63 = 64'hC90FDAA22168C234;

  typedef logic signed [15:0] q_t;
  typedef logic signed [TransW-1:0] tr_t;

  typedef struct packed {
    tr_t x;
    tr_t y;
    tr_t z;
  } trans_t;

  typedef struct packed {
    q_t sy;
    q_t cy;
    q_t sp;
    q_t cp;
    q_t sr;
    q_t cr;
  } trig_t;

  // first product rank
  typedef struct packed {
    q_t cycr;
    q_t sysp;
    q_t crsy;
    q_t srcy;
    q_t sysr;
    q_t sp;
    q_t sr;
    q_t m2;
    q_t m3;
    q_t m4;
    q_t m5;
    q_t m8;
  } prod1_t;

  // second product rank
  typedef struct packed {
    q_t cycr;
    q_t crsy;
    q_t srcy;
    q_t sysr;
    q_t q0;
    q_t q1;
    q_t q6;
    q_t q7;
    q_t m2;
    q_t m3;
    q_t m4;
    q_t m5;
    q_t m8;
  } prod2_t;

  typedef struct packed {
    q_t r0c0;
    q_t r1c0;
    q_t r2c0;
    q_t r0c1;
    q_t r1c1;
    q_t r2c1;
    q_t r0c2;
    q_t r1c2;
    q_t r2c2;
  } mat_t;

  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(16384*sin(pi/2*k/2^(bits-2))) from a Taylor series in Q62
  function automatic q_t sine_entry(input int k, input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] rnd;
    x = mul_shift(HalfPiQ63, 64'(k), bits - 1);
    x2 = mul_shift(x, x, 62);
    term = x;
    sum = x;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        den = 64'((2 * n) * (2 * n + 1));
        term = div_u64(mul_shift(term, x2, 62), den);
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    rnd = (sum + (64'd1 << 47)) >> 48;
    return q_t'(rnd[15:0]);
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [31:0] p;
    p = 32'(a) * 32'(b) + 32'sd8192;
    p = p >>> QFrac;
    return q_t'(p[15:0]);
  endfunction

  function automatic q_t sat(input logic signed [16:0] v);
    if (v > 17'sd16384) return 16'sd16384;
    if (v < -17'sd16384) return -16'sd16384;
    return q_t'(v[15:0]);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/etrm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface etrm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, trans_x, trans_y,
                  trans_z, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, trans_x, trans_y,
                trans_z, output ready);
endinterface

interface etrm_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] rot_r0_c0;
  logic signed [15:0] rot_r1_c0;
  logic signed [15:0] rot_r2_c0;
  logic signed [15:0] rot_r0_c1;
  logic signed [15:0] rot_r1_c1;
  logic signed [15:0] rot_r2_c1;
  logic signed [15:0] rot_r0_c2;
  logic signed [15:0] rot_r1_c2;
  logic signed [15:0] rot_r2_c2;
  logic signed [31:0] out_trans_x;
  logic signed [31:0] out_trans_y;
  logic signed [31:0] out_trans_z;

  modport source (output valid, rot_r0_c0, rot_r1_c0, rot_r2_c0, rot_r0_c1, rot_r1_c1,
                  rot_r2_c1, rot_r0_c2, rot_r1_c2, rot_r2_c2, out_trans_x, out_trans_y,
                  out_trans_z, input ready);
  modport sink (input valid, rot_r0_c0, rot_r1_c0, rot_r2_c0, rot_r0_c1, rot_r1_c1,
                rot_r2_c1, rot_r0_c2, rot_r1_c2, rot_r2_c2, out_trans_x, out_trans_y,
                out_trans_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/euler_to_rotation_matrix.sv -----
// channel   dir  beat
// in_ch     in   yaw/pitch/roll angles, translation x/y/z
// out_ch    out  nine Q2.14 rotation entries, translation x/y/z
//
// One beat per cycle unless the sink stalls; stages: table lookup, two
// product ranks, saturating sums. The output stage is the last pipeline
// register. Each stage holds its beat while the next one is full and
// stalled, so bubbles close up under backpressure. Sync active-low reset
// clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_rotation_matrix #(
  parameter int SINE_TABLE_BITS = etrm_pkg::SineTableBitsDef
) (
  input wire clk,
  input wire rst_n,
  etrm_in_if.sink in_ch,
  etrm_out_if.source out_ch
);
  import etrm_pkg::*;

  logic v1, r1, v2, r2, v3, r3;
  trans_t tr_in, tr1, tr2, tr3, tr4;
  trig_t trig1;
  prod1_t p1;
  prod2_t p2;
  mat_t mat;

  assign tr_in.x = in_ch.trans_x;
  assign tr_in.y = in_ch.trans_y;
  assign tr_in.z = in_ch.trans_z;

  etrm_sincos #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sincos (
    .clk, .rst_n,
    .valid_i(in_ch.valid), .ready_o(in_ch.ready),
    .yaw_i(in_ch.yaw_angle), .pitch_i(in_ch.pitch_angle), .roll_i(in_ch.roll_angle),
    .trans_i(tr_in),
    .valid_o(v1), .ready_i(r1), .trig_o(trig1), .trans_o(tr1)
  );

  etrm_prod1 u_prod1 (
    .clk, .rst_n,
    .valid_i(v1), .ready_o(r1), .trig_i(trig1), .trans_i(tr1),
    .valid_o(v2), .ready_i(r2), .prod_o(p1), .trans_o(tr2)
  );

  etrm_prod2 u_prod2 (
    .clk, .rst_n,
    .valid_i(v2), .ready_o(r2), .prod_i(p1), .trans_i(tr2),
    .valid_o(v3), .ready_i(r3), .prod_o(p2), .trans_o(tr3)
  );

  etrm_sum u_sum (
    .clk, .rst_n,
    .valid_i(v3), .ready_o(r3), .prod_i(p2), .trans_i(tr3),
    .valid_o(out_ch.valid), .ready_i(out_ch.ready), .mat_o(mat), .trans_o(tr4)
  );

  assign out_ch.rot_r0_c0 = mat.r0c0;
  assign out_ch.rot_r1_c0 = mat.r1c0;
  assign out_ch.rot_r2_c0 = mat.r2c0;
  assign out_ch.rot_r0_c1 = mat.r0c1;
  assign out_ch.rot_r1_c1 = mat.r1c1;
  assign out_ch.rot_r2_c1 = mat.r2c1;
  assign out_ch.rot_r0_c2 = mat.r0c2;
  assign out_ch.rot_r1_c2 = mat.r1c2;
  assign out_ch.rot_r2_c2 = mat.r2c2;
  assign out_ch.out_trans_x = tr4.x;
  assign out_ch.out_trans_y = tr4.y;
  assign out_ch.out_trans_z = tr4.z;

  // input only blocks when every stage is full and the sink stalls
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1 && v2 && v3 && out_ch.valid && !out_ch.ready))
    else $error("input stalled with a bubble in the pipe");

  a_sat_r0c0: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.rot_r0_c0 <= 16'sd16384 && out_ch.rot_r0_c0 >= -16'sd16384))
    else $error("r0c0 out of range");

  a_sat_r1c2: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.rot_r1_c2 <= 16'sd16384 && out_ch.rot_r1_c2 >= -16'sd16384))
    else $error("r1c2 out of range");

endmodule

`default_nettype wire

// ----- rtl/core/etrm_sincos.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etrm_sincos #(
  parameter int SINE_TABLE_BITS = etrm_pkg::SineTableBitsDef
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    valid_i,
  output logic                   ready_o,
  input  wire [15:0]             yaw_i,
  input  wire [15:0]             pitch_i,
  input  wire [15:0]             roll_i,
  input  etrm_pkg::trans_t       trans_i,
  output logic                   valid_o,
  input  wire                    ready_i,
  output etrm_pkg::trig_t        trig_o,
  output etrm_pkg::trans_t       trans_o
);
  import etrm_pkg::*;

  localparam int IdxW = SINE_TABLE_BITS;
  localparam int QW = SINE_TABLE_BITS - 2;
  localparam int QLen = 1 << QW;

  typedef q_t tab_t [0:QLen];

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k <= QLen; k++) t[k] = sine_entry(k, SINE_TABLE_BITS);
    return t;
  endfunction

  localparam tab_t Tab = build_tab();

  function automatic q_t sine_of(input logic [IdxW-1:0] i);
    logic [1:0] quad;
    logic [QW-1:0] q;
    logic [QW:0] mir;
    q_t v;
    quad = i[IdxW-1 -: 2];
    q = i[QW-1:0];
    mir = (QW + 1)'(QLen) - {1'b0, q};
    v = quad[0] ? Tab[mir] : Tab[q];
    return quad[1] ? -v : v;
  endfunction

  function automatic logic [IdxW-1:0] cos_idx(input logic [IdxW-1:0] i);
    return i + IdxW'(QLen);
  endfunction

  logic [IdxW-1:0] iy, ip, ir;
  logic valid_r;
  trig_t trig_r, trig_nxt;
  trans_t trans_r;

  assign iy = yaw_i[15 -: IdxW];
  assign ip = pitch_i[15 -: IdxW];
  assign ir = roll_i[15 -: IdxW];

  always_comb begin
    trig_nxt.sy = sine_of(iy);
    trig_nxt.cy = sine_of(cos_idx(iy));
    trig_nxt.sp = sine_of(ip);
    trig_nxt.cp = sine_of(cos_idx(ip));
    trig_nxt.sr = sine_of(ir);
    trig_nxt.cr = sine_of(cos_idx(ir));
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      trig_r <= trig_nxt;
      trans_r <= trans_i;
    end
  end

  assign valid_o = valid_r;
  assign trig_o = trig_r;
  assign trans_o = trans_r;

endmodule

`default_nettype wire

// ----- rtl/core/etrm_prod1.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etrm_prod1 (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               valid_i,
  output logic              ready_o,
  input  etrm_pkg::trig_t   trig_i,
  input  etrm_pkg::trans_t  trans_i,
  output logic              valid_o,
  input  wire               ready_i,
  output etrm_pkg::prod1_t  prod_o,
  output etrm_pkg::trans_t  trans_o
);
  import etrm_pkg::*;

  logic valid_r;
  prod1_t prod_r, prod_nxt;
  trans_t trans_r;

  always_comb begin
    prod_nxt.cycr = qmul(trig_i.cy, trig_i.cr);
    prod_nxt.sysp = qmul(trig_i.sy, trig_i.sp);
    prod_nxt.crsy = qmul(trig_i.cr, trig_i.sy);
    prod_nxt.srcy = qmul(trig_i.sr, trig_i.cy);
    prod_nxt.sysr = qmul(trig_i.sy, trig_i.sr);
    prod_nxt.sp = trig_i.sp;
    prod_nxt.sr = trig_i.sr;
    prod_nxt.m2 = qmul(trig_i.cp, trig_i.sy);
    prod_nxt.m3 = qmul(trig_i.cp, trig_i.sr);
    prod_nxt.m4 = qmul(trig_i.cr, trig_i.cp);
    prod_nxt.m5 = -trig_i.sp;
    prod_nxt.m8 = qmul(trig_i.cp, trig_i.cy);
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      prod_r <= prod_nxt;
      trans_r <= trans_i;
    end
  end

  assign valid_o = valid_r;
  assign prod_o = prod_r;
  assign trans_o = trans_r;

endmodule

`default_nettype wire

// ----- rtl/core/etrm_prod2.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etrm_prod2 (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               valid_i,
  output logic              ready_o,
  input  etrm_pkg::prod1_t  prod_i,
  input  etrm_pkg::trans_t  trans_i,
  output logic              valid_o,
  input  wire               ready_i,
  output etrm_pkg::prod2_t  prod_o,
  output etrm_pkg::trans_t  trans_o
);
  import etrm_pkg::*;

  logic valid_r;
  prod2_t prod_r, prod_nxt;
  trans_t trans_r;

  always_comb begin
    prod_nxt.cycr = prod_i.cycr;
    prod_nxt.crsy = prod_i.crsy;
    prod_nxt.srcy = prod_i.srcy;
    prod_nxt.sysr = prod_i.sysr;
    prod_nxt.q0 = qmul(prod_i.sysp, prod_i.sr);
    prod_nxt.q1 = qmul(prod_i.crsy, prod_i.sp);
    prod_nxt.q6 = qmul(prod_i.srcy, prod_i.sp);
    prod_nxt.q7 = qmul(prod_i.cycr, prod_i.sp);
    prod_nxt.m2 = prod_i.m2;
    prod_nxt.m3 = prod_i.m3;
    prod_nxt.m4 = prod_i.m4;
    prod_nxt.m5 = prod_i.m5;
    prod_nxt.m8 = prod_i.m8;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      prod_r <= prod_nxt;
      trans_r <= trans_i;
    end
  end

  assign valid_o = valid_r;
  assign prod_o = prod_r;
  assign trans_o = trans_r;

endmodule

`default_nettype wire

// ----- rtl/core/etrm_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none

module etrm_sum (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               valid_i,
  output logic              ready_o,
  input  etrm_pkg::prod2_t  prod_i,
  input  etrm_pkg::trans_t  trans_i,
  output logic              valid_o,
  input  wire               ready_i,
  output etrm_pkg::mat_t    mat_o,
  output etrm_pkg::trans_t  trans_o
);
  import etrm_pkg::*;

  logic valid_r;
  mat_t mat_r, mat_nxt;
  trans_t trans_r;

  always_comb begin
    mat_nxt.r0c0 = sat(17'(prod_i.cycr) + 17'(prod_i.q0));
    mat_nxt.r1c0 = sat(17'(prod_i.q1) - 17'(prod_i.srcy));
    mat_nxt.r2c0 = prod_i.m2;
    mat_nxt.r0c1 = prod_i.m3;
    mat_nxt.r1c1 = prod_i.m4;
    mat_nxt.r2c1 = prod_i.m5;
    mat_nxt.r0c2 = sat(17'(prod_i.q6) - 17'(prod_i.crsy));
    mat_nxt.r1c2 = sat(17'(prod_i.sysr) + 17'(prod_i.q7));
    mat_nxt.r2c2 = prod_i.m8;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      mat_r <= mat_nxt;
      trans_r <= trans_i;
    end
  end

  assign valid_o = valid_r;
  assign mat_o = mat_r;
  assign trans_o = trans_r;

endmodule

`default_nettype wire
